/* src/bfcf_pkg.sv */
// ----------------------------------------------------------------------------
// bfcf_pkg
// Shared types, constants and the microcode table for the baud fraction
// solver (continued-fraction best rational approximation).
// ----------------------------------------------------------------------------
package bfcf_pkg;

  // Field widths
  localparam int BAUD_W = 24;
  localparam int CLK_W  = 29;
  localparam int OVS_W  = 5;
  localparam int FLD_W  = 12;
  localparam int STS_W  = 2;

  // Configuration port
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = CLK_W;
  localparam logic [OVS_W-1:0] OVS_RESET = OVS_W'(16);

  // Solver limits
  localparam int DENOM_LIMIT = 4095;
  localparam int NUM_MAX     = 4095;

  // Euclid operands: baud * oversampling and the clock both fit in P_W bits
  localparam int P_W   = CLK_W;
  localparam int CNT_W = $clog2(P_W);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(P_W - 1);

  // Convergent registers; quotient and numerator saturate at A_CAP
  localparam int DEN_W = $clog2(DENOM_LIMIT + 1);
  localparam int A_CAP = ((DENOM_LIMIT > NUM_MAX) ? DENOM_LIMIT : NUM_MAX) + 1;
  localparam int A_W   = $clog2(A_CAP + 1);
  localparam int H_W   = A_W;
  localparam int MUL_W = 2 * A_W;

  // Result status codes
  typedef enum logic [STS_W-1:0] {
    ST_OK       = 2'd0,
    ST_CLK_ZERO = 2'd1,
    ST_NUM_OVF  = 2'd2
  } status_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CLOCK = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_OVS   = 1'b1;

  // Micro-operations driving the datapath
  typedef enum logic [2:0] {
    OP_WAIT,    // accept an input item
    OP_INIT,    // load operands, clear convergents
    OP_DIV,     // one restoring division bit
    OP_TEST,    // compare next denominator with the limit
    OP_UPDATE,  // advance the convergents
    OP_NEXT,    // shift the Euclid pair, restart the divider
    OP_EMIT,    // load the output register
    OP_NOP
  } op_t;

  // Jump conditions
  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_CLK_ZERO,
    C_DIV_BUSY,
    C_LIMIT,
    C_REM_ZERO,
    C_OUT_BUSY
  } cond_t;

  localparam int STEP_W = 3;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t S_WAIT   = 3'd0;
  localparam step_t S_INIT   = 3'd1;
  localparam step_t S_DIV    = 3'd2;
  localparam step_t S_TEST   = 3'd3;
  localparam step_t S_UPDATE = 3'd4;
  localparam step_t S_NEXT   = 3'd5;
  localparam step_t S_EMIT   = 3'd6;
  localparam step_t S_DONE   = 3'd7;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t jump;
  } ucode_t;

  // Datapath status seen by the sequencer
  typedef struct packed {
    logic in_valid;
    logic clk_zero;
    logic div_last;
    logic limit;
    logic rem_zero;
    logic out_busy;
  } flags_t;

  // Microcode program: jump to target when the condition holds, else step on
  function automatic ucode_t ucode_rom(input step_t addr);
    ucode_t w;
    unique case (addr)
      S_WAIT:   w = '{op: OP_WAIT,   cond: C_NO_INPUT, jump: S_WAIT};
      S_INIT:   w = '{op: OP_INIT,   cond: C_CLK_ZERO, jump: S_EMIT};
      S_DIV:    w = '{op: OP_DIV,    cond: C_DIV_BUSY, jump: S_DIV};
      S_TEST:   w = '{op: OP_TEST,   cond: C_LIMIT,    jump: S_EMIT};
      S_UPDATE: w = '{op: OP_UPDATE, cond: C_REM_ZERO, jump: S_EMIT};
      S_NEXT:   w = '{op: OP_NEXT,   cond: C_ALWAYS,   jump: S_DIV};
      S_EMIT:   w = '{op: OP_EMIT,   cond: C_OUT_BUSY, jump: S_EMIT};
      S_DONE:   w = '{op: OP_NOP,    cond: C_ALWAYS,   jump: S_WAIT};
      default:  w = '{op: OP_NOP,    cond: C_ALWAYS,   jump: S_WAIT};
    endcase
    return w;
  endfunction

endpackage

/* src/bfcf_seq.sv */
// ----------------------------------------------------------------------------
// bfcf_seq
// Microcode sequencer: step counter, program table lookup and conditional
// jump. Hands the current micro-operation to the datapath.
// ----------------------------------------------------------------------------
module bfcf_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  bfcf_pkg::flags_t  flags,
  output bfcf_pkg::op_t     op
);
  import bfcf_pkg::*;

  step_t  pc_r;
  step_t  pc_nxt;
  ucode_t uw;
  logic   take;

  // Fetch the control word
  assign uw = ucode_rom(pc_r);
  assign op = uw.op;

  // Evaluate the jump condition
  always_comb begin
    unique case (uw.cond)
      C_NEVER:    take = 1'b0;
      C_ALWAYS:   take = 1'b1;
      C_NO_INPUT: take = !flags.in_valid;
      C_CLK_ZERO: take = flags.clk_zero;
      C_DIV_BUSY: take = !flags.div_last;
      C_LIMIT:    take = flags.limit;
      C_REM_ZERO: take = flags.rem_zero;
      C_OUT_BUSY: take = flags.out_busy;
      default:    take = 1'b0;
    endcase
  end

  assign pc_nxt = take ? uw.jump : step_t'(pc_r + 1'b1);

  // Advance the step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= S_WAIT;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

/* src/baud_fraction_continued_fraction.sv */
// ----------------------------------------------------------------------------
// baud_fraction_continued_fraction
// Approximates (baud * oversampling) / clock by the last continued-fraction
// convergent whose denominator stays within the limit, using exact Euclid
// steps on a microcoded datapath with a bit-serial restoring divider.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+-------------------------------------
//  in      | input     | in_valid/in_stall | in_baud_rate
//  out     | output    | out_valid/out_stall | out_numerator, out_denominator, out_status
//  cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  Each continued-fraction term runs the one-bit-per-cycle divider over the
//  full operand width, then limit test, convergent update and operand shift.
//  An item ends when a zero remainder or the limit ends it (terms up to about
//  18); the emit step waits while the output register is stalled. A zero
//  clock goes from init straight to emit. The next item is taken while the last
//  result waits in the output register. Reset sets the clock register to
//  zero and oversampling to 16; cfg_ready is always high.
//
module baud_fraction_continued_fraction (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [bfcf_pkg::BAUD_W-1:0]    in_baud_rate,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [bfcf_pkg::FLD_W-1:0]     out_numerator,
  output logic [bfcf_pkg::FLD_W-1:0]     out_denominator,
  output logic [bfcf_pkg::STS_W-1:0]     out_status,
  // configuration channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bfcf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bfcf_pkg::CFG_DAT_W-1:0] cfg_data
);
  import bfcf_pkg::*;

  op_t    op;
  flags_t flags;

  // Configuration registers
  logic [CLK_W-1:0]  clock_r;
  logic [OVS_W-1:0]  ovs_r;

  // Datapath registers
  logic [BAUD_W-1:0] baud_r,   baud_nxt;
  logic [P_W-1:0]    divd_r,   divd_nxt;   // dividend, shifts into quotient
  logic [P_W-1:0]    q_r,      q_nxt;      // divisor
  logic [P_W-1:0]    rem_r,    rem_nxt;
  logic [CNT_W-1:0]  cnt_r,    cnt_nxt;
  logic [H_W-1:0]    h_r,      h_nxt;
  logic [H_W-1:0]    hp_r,     hp_nxt;
  logic [DEN_W-1:0]  k_r,      k_nxt;
  logic [DEN_W-1:0]  kp_r,     kp_nxt;
  logic              zclk_r,   zclk_nxt;

  // Output register
  logic              out_valid_r;
  logic [FLD_W-1:0]  num_r;
  logic [FLD_W-1:0]  den_r;
  status_t           sts_r;
  logic              emit;

  // Combinational helpers
  logic [P_W:0]      rem_sh;
  logic [P_W:0]      rem_sub;
  logic              ge;
  logic [A_W-1:0]    a_sat;
  logic [MUL_W-1:0]  kden;
  logic [MUL_W-1:0]  hnum;
  logic              in_xfer;
  logic              out_xfer;

  bfcf_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .op    (op)
  );

  assign in_stall  = (op != OP_WAIT);
  assign cfg_ready = 1'b1;
  assign in_xfer   = in_valid && !in_stall;
  assign out_xfer  = out_valid_r && !out_stall;

  // Restoring division step
  assign rem_sh  = {rem_r, divd_r[P_W-1]};
  assign rem_sub = rem_sh - {1'b0, q_r};
  assign ge      = (rem_sh >= {1'b0, q_r});

  // Quotient capped so that products stay narrow; a capped quotient
  // already forces the limit, or numerator overflow on the first term
  assign a_sat = (divd_r > P_W'(A_CAP - 1)) ? A_W'(A_CAP) : A_W'(divd_r);

  // Next convergent terms
  assign kden = MUL_W'(k_r) * MUL_W'(a_sat) + MUL_W'(kp_r);
  assign hnum = MUL_W'(h_r) * MUL_W'(a_sat) + MUL_W'(hp_r);

  // Sequencer flags
  assign flags.in_valid = in_valid;
  assign flags.clk_zero = (clock_r == '0);
  assign flags.div_last = (cnt_r == DIV_LAST);
  assign flags.limit    = (kden > MUL_W'(DENOM_LIMIT));
  assign flags.rem_zero = (rem_r == '0);
  assign flags.out_busy = out_valid_r && out_stall;

  assign emit = (op == OP_EMIT) && !flags.out_busy;

  // Datapath next values
  always_comb begin
    baud_nxt = baud_r;
    divd_nxt = divd_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    h_nxt    = h_r;
    hp_nxt   = hp_r;
    k_nxt    = k_r;
    kp_nxt   = kp_r;
    zclk_nxt = zclk_r;
    unique case (op) inside
      OP_WAIT: begin
        if (in_xfer) begin
          baud_nxt = in_baud_rate;
        end
      end
      OP_INIT: begin
        divd_nxt = P_W'(baud_r) * P_W'(ovs_r);
        q_nxt    = clock_r;
        rem_nxt  = '0;
        cnt_nxt  = '0;
        h_nxt    = H_W'(1);
        hp_nxt   = '0;
        k_nxt    = '0;
        kp_nxt   = DEN_W'(1);
        zclk_nxt = (clock_r == '0);
      end
      OP_DIV: begin
        rem_nxt  = ge ? rem_sub[P_W-1:0] : rem_sh[P_W-1:0];
        divd_nxt = {divd_r[P_W-2:0], ge};
        cnt_nxt  = CNT_W'(cnt_r + 1'b1);
      end
      OP_UPDATE: begin
        h_nxt  = (hnum > MUL_W'(A_CAP)) ? H_W'(A_CAP) : hnum[H_W-1:0];
        hp_nxt = h_r;
        k_nxt  = kden[DEN_W-1:0];
        kp_nxt = k_r;
      end
      OP_NEXT: begin
        divd_nxt = q_r;
        q_nxt    = rem_r;
        rem_nxt  = '0;
        cnt_nxt  = '0;
      end
      OP_TEST, OP_EMIT, OP_NOP: begin
      end
      default: begin
      end
    endcase
  end

  // Hold datapath payload
  always_ff @(posedge clk) begin
    baud_r <= baud_nxt;
    divd_r <= divd_nxt;
    q_r    <= q_nxt;
    rem_r  <= rem_nxt;
    cnt_r  <= cnt_nxt;
    h_r    <= h_nxt;
    hp_r   <= hp_nxt;
    k_r    <= k_nxt;
    kp_r   <= kp_nxt;
    zclk_r <= zclk_nxt;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_r <= '0;
      ovs_r   <= OVS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CLOCK: clock_r <= cfg_data;
        REG_OVS:   ovs_r   <= cfg_data[OVS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Output valid: set on emit, drop on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_xfer) begin
      out_valid_r <= 1'b0;
    end
  end

  // Load the result payload
  always_ff @(posedge clk) begin
    if (emit) begin
      if (zclk_r) begin
        num_r <= '0;
        den_r <= '0;
        sts_r <= ST_CLK_ZERO;
      end else if (h_r > H_W'(NUM_MAX)) begin
        num_r <= '0;
        den_r <= FLD_W'(k_r);
        sts_r <= ST_NUM_OVF;
      end else begin
        num_r <= FLD_W'(h_r);
        den_r <= FLD_W'(k_r);
        sts_r <= ST_OK;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_numerator   = num_r;
  assign out_denominator = den_r;
  assign out_status      = sts_r;

endmodule

/* tb/sv/fraction_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fraction_checker
// Watches the configuration, request and result channels of the baud
// fraction solver. Keeps its own copy of the clock and oversampling
// registers, and solves each accepted baud request by exact continued-
// fraction steps. Checks every result against the oldest open prediction.
// ----------------------------------------------------------------------------
module fraction_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [bfcf_pkg::BAUD_W-1:0]    in_baud_rate,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [bfcf_pkg::FLD_W-1:0]     out_numerator,
  input  logic [bfcf_pkg::FLD_W-1:0]     out_denominator,
  input  logic [bfcf_pkg::STS_W-1:0]     out_status,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [bfcf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bfcf_pkg::CFG_DAT_W-1:0] cfg_data,
  output int                             fail_count,
  output int                             open_count,
  output int                             checked_count
);
  import bfcf_pkg::*;

  typedef struct packed {
    logic [FLD_W-1:0] num;
    logic [FLD_W-1:0] den;
    status_t          sts;
  } fraction_t;

  logic [CLK_W-1:0] clock_hz;
  logic [OVS_W-1:0] ovs;
  fraction_t        expected_fractions[$];

  // Walk the convergents of baud*ovs/clock until the denominator would pass the limit
  function automatic fraction_t solve_fraction(input logic [BAUD_W-1:0] baud);
    fraction_t       res;
    longint unsigned num_op, den_op, quot, rem;
    longint unsigned h, h_prev, k, k_prev, tmp;
    bit              done;
    res.num = '0;
    res.den = '0;
    res.sts = ST_OK;
    if (clock_hz == '0) begin
      res.sts = ST_CLK_ZERO;
      return res;
    end
    h      = 1;
    h_prev = 0;
    k      = 0;
    k_prev = 1;
    num_op = longint'(baud) * longint'(ovs);
    den_op = longint'(clock_hz);
    done   = 1'b0;
    while (!done) begin
      quot = num_op / den_op;
      rem  = num_op % den_op;
      if (k * quot + k_prev > longint'(DENOM_LIMIT)) begin
        done = 1'b1;
      end else begin
        tmp    = h * quot + h_prev;
        h_prev = h;
        h      = tmp;
        tmp    = k * quot + k_prev;
        k_prev = k;
        k      = tmp;
        // zero remainder: last convergent is exact
        if (rem == 0) begin
          done = 1'b1;
        end else begin
          num_op = den_op;
          den_op = rem;
        end
      end
    end
    res.den = k[FLD_W-1:0];
    if (h > longint'(NUM_MAX)) begin
      res.sts = ST_NUM_OVF;
    end else begin
      res.num = h[FLD_W-1:0];
    end
    return res;
  endfunction

  // Track registers, queue predictions, compare results
  always @(posedge clk) begin
    fraction_t want;
    if (!rst_n) begin
      clock_hz = '0;
      ovs      = OVS_RESET;
      expected_fractions.delete();
      fail_count    <= 0;
      open_count    <= 0;
      checked_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_CLOCK) begin
          clock_hz = cfg_data;
        end else if (cfg_index == REG_OVS) begin
          ovs = cfg_data[OVS_W-1:0];
        end
      end
      if (in_valid && !in_stall) begin
        expected_fractions.push_back(solve_fraction(in_baud_rate));
      end
      if (out_valid && !out_stall) begin
        checked_count <= checked_count + 1;
        if (expected_fractions.size() == 0) begin
          $error("result with no open request: num %0d den %0d status %0d",
                 out_numerator, out_denominator, out_status);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_fractions.pop_front();
          if (out_numerator !== want.num) begin
            $error("numerator mismatch: expected %0d, actual %0d", want.num, out_numerator);
          end
          if (out_denominator !== want.den) begin
            $error("denominator mismatch: expected %0d, actual %0d",
                   want.den, out_denominator);
          end
          if (out_status !== want.sts) begin
            $error("status mismatch: expected %0d, actual %0d", want.sts, out_status);
          end
          if (out_numerator !== want.num || out_denominator !== want.den ||
              out_status !== want.sts) begin
            fail_count <= fail_count + 1;
          end
        end
      end
      open_count <= expected_fractions.size();
    end
  end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives baud requests and register writes into the baud fraction solver
// and leaves prediction to fraction_checker. Directed requests cover zero
// clock, zero ratio, exact ratios and numerator overflow; random phases
// sweep clock and oversampling settings under several idle/stall mixes.
// ----------------------------------------------------------------------------
module testbench;
  import bfcf_pkg::*;

  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 104;
  localparam int DRAIN_CYCLES  = 700;
  localparam int STUCK_LIMIT   = 20000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [BAUD_W-1:0]    in_baud_rate = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [FLD_W-1:0]     out_numerator;
  logic [FLD_W-1:0]     out_denominator;
  logic [STS_W-1:0]     out_status;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  int fail_count;
  int open_count;
  int checked_count;
  int idle_pct = 0;
  int stall_pct = 0;
  int requests_sent = 0;
  int writes_done = 0;
  int stuck_cycles = 0;

  baud_fraction_continued_fraction i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_baud_rate    (in_baud_rate),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_numerator   (out_numerator),
    .out_denominator (out_denominator),
    .out_status      (out_status),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  fraction_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_baud_rate    (in_baud_rate),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_numerator   (out_numerator),
    .out_denominator (out_denominator),
    .out_status      (out_status),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .open_count      (open_count),
    .checked_count   (checked_count)
  );

  always #10 clk = ~clk;

  // Stall the result channel at random
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Count cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    wait (stuck_cycles >= STUCK_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Write one register once every open request has been answered
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    while (open_count != 0) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
    writes_done++;
  endtask

  // Send one baud request, idling first at the current rate; drop valid after the transfer
  task automatic send_baud(input logic [BAUD_W-1:0] baud);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_baud_rate <= baud;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    in_valid <= 1'b0;
    @(negedge clk);
    requests_sent++;
  endtask

  function automatic logic [BAUD_W-1:0] pick_baud();
    int unsigned std_rates[14] = '{300, 1200, 2400, 4800, 9600, 19200, 38400, 57600,
                                   115200, 230400, 460800, 921600, 1000000, 3000000};
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 30) begin
      return BAUD_W'(std_rates[$urandom_range(13)]);
    end else if (roll < 45) begin
      return BAUD_W'($urandom_range(1000));
    end else begin
      return BAUD_W'($urandom_range(24'hFF_FFFF));
    end
  endfunction

  initial begin
    logic [CLK_W-1:0] clk_word;
    logic [OVS_W-1:0] ovs_val;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: zero clock straight out of reset
    send_baud('0);
    send_baud('1);

    // Typical clock: zero ratio, common rates, exact ratio, numerator overflow
    write_reg(REG_CLOCK, CLK_W'(48_000_000));
    write_reg(REG_OVS, CLK_W'(16));
    send_baud('0);
    send_baud(BAUD_W'(9600));
    send_baud(BAUD_W'(115200));
    send_baud(BAUD_W'(3_000_000));
    send_baud(BAUD_W'(1_000_000));
    send_baud('1);

    // Zero oversampling gives a zero ratio
    write_reg(REG_OVS, CLK_W'(0));
    send_baud(BAUD_W'(12345));

    // Clock of one: a single huge quotient
    write_reg(REG_CLOCK, CLK_W'(1));
    write_reg(REG_OVS, CLK_W'(31));
    send_baud('1);
    send_baud(BAUD_W'(1));
    send_baud(BAUD_W'(132));

    // Largest clock with tiny ratio, then largest ratio
    write_reg(REG_CLOCK, '1);
    write_reg(REG_OVS, CLK_W'(1));
    send_baud(BAUD_W'(1));
    send_baud('1);
    send_baud(BAUD_W'(24'hAAAAAA));
    send_baud(BAUD_W'(24'h555555));

    // Random phases, each with its own settings and idle/stall mix
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin clk_word = CLK_W'(500_000_000); ovs_val = OVS_W'(16); end
        1: begin clk_word = '1; ovs_val = OVS_W'(31); end
        2: begin clk_word = CLK_W'($urandom_range(1, 4096)); ovs_val = OVS_W'(1); end
        3: begin clk_word = '0; ovs_val = OVS_W'(0); end
        default: begin
          clk_word = CLK_W'($urandom_range(1, 29'h1FFF_FFFF));
          ovs_val  = OVS_W'($urandom_range(31));
        end
      endcase
      write_reg(REG_CLOCK, clk_word);
      // upper data bits are ignored by the oversampling register
      write_reg(REG_OVS, (CLK_W'($urandom) & ~CLK_W'(5'h1F)) | CLK_W'(ovs_val));
      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 85; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 85; end
        default: begin idle_pct = 14; stall_pct = 14; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // hold off mid-phase until every open request has been answered
        if (phase == 2 && n == PHASE_ITEMS / 2) begin
          in_valid <= 1'b0;
          while (open_count != 0) @(negedge clk);
          @(negedge clk);
        end
        send_baud(pick_baud());
      end
    end

    // Drop valid and drain
    in_valid <= 1'b0;
    while (open_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Covered %0d baud requests and %0d checked results across %0d register writes,",
             requests_sent, checked_count, writes_done);
    $display("including zero clock, zero ratio, exact ratios and numerator overflow.");
    if (fail_count == 0 && open_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
